@@ rtl/bp_pkg.sv @@
// Shared package for the relativistic Boris push pipeline.
// Holds payload structs, configuration register codes, sizes and Q8.24 helpers.
// No dependencies.
package bp_pkg;

    localparam int SQ_BITS    = 32;
    localparam int SQ_STEPS   = 2;
    localparam int SQ_STAGES  = SQ_BITS / SQ_STEPS;
    localparam int DIV_QBITS  = 40;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = DIV_QBITS / DIV_STEPS;

    localparam logic signed [65:0] W_MAX = 66'sd2147483647;
    localparam logic signed [65:0] W_MIN = -66'sd2147483648;

    typedef enum logic {
        CFG_EKICK = 1'b0,
        CFG_MROT  = 1'b1
    } t_cfg_reg;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        t_q mom_z;
        t_q mom_r;
        t_q mom_phi;
        t_q efield_z;
        t_q efield_r;
        t_q efield_phi;
        t_q bfield_z;
        t_q bfield_r;
        t_q bfield_phi;
    } t_in_item;

    typedef struct packed {
        t_q   new_mom_z;
        t_q   new_mom_r;
        t_q   new_mom_phi;
        logic saturated;
    } t_out_item;

    // {clipped flag, value} clipped to the signed 32-bit range
    function automatic logic [32:0] sat32(input logic signed [65:0] x);
        logic [32:0] r;
        if (x > W_MAX) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (x < W_MIN) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

    // Q16.48 back to Q8.24, round half up
    function automatic logic signed [65:0] rnd24(input logic signed [65:0] x);
        logic signed [65:0] y;
        y = x + 66'sd8388608;
        return y >>> 24;
    endfunction

endpackage

@@ rtl/bp_sqrt.sv @@
// Pipelined integer square root, floor(sqrt(64-bit)), two result bits per stage.
// Depends on bp_pkg for stage sizing.
module bp_sqrt import bp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } t_sq_st;

    t_sq_st r_st [SQ_STAGES];
    t_sq_st w_src [SQ_STAGES];
    t_sq_st n_st [SQ_STAGES];

    function automatic t_sq_st sq_step(input t_sq_st x);
        logic [34:0] w;
        logic [34:0] trial;
        t_sq_st y;
        w     = {x.rem, x.rad[63:62]};
        trial = {1'b0, x.root, 2'b01};
        if (w >= trial) begin
            y.rem  = 33'(w - trial);
            y.root = {x.root[30:0], 1'b1};
        end else begin
            y.rem  = w[32:0];
            y.root = {x.root[30:0], 1'b0};
        end
        y.rad = {x.rad[61:0], 2'b00};
        return y;
    endfunction

    always_comb begin
        t_sq_st cur;
        w_src[0] = '{rem: '0, root: '0, rad: i_rad};
        for (int s = 1; s < SQ_STAGES; s++) begin
            w_src[s] = r_st[s-1];
        end
        for (int s = 0; s < SQ_STAGES; s++) begin
            cur = w_src[s];
            for (int k = 0; k < SQ_STEPS; k++) begin
                cur = sq_step(cur);
            end
            n_st[s] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < SQ_STAGES; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_root = r_st[SQ_STAGES-1].root;

endmodule

@@ rtl/bp_div.sv @@
// Pipelined three-lane restoring divider with a shared divisor, 40 quotient bits.
// Numerator 64 bits, divisor 48 bits and at least 2^24. Depends on bp_pkg.
module bp_div import bp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [2:0][63:0] i_num,
    input  logic [47:0]      i_den,
    output logic [2:0][39:0] o_quo
);

    typedef struct packed {
        logic [47:0] rem;
        logic [39:0] nq;    // numerator bits still to shift in, quotient bits out
    } t_lane;

    t_lane       r_ln  [DIV_STAGES][3];
    t_lane       w_src [DIV_STAGES][3];
    t_lane       n_ln  [DIV_STAGES][3];
    logic [47:0] r_den [DIV_STAGES];
    logic [47:0] w_den [DIV_STAGES];

    function automatic t_lane div_step(input t_lane x, input logic [47:0] d);
        logic [48:0] w;
        logic        ge;
        t_lane       y;
        w     = {x.rem, x.nq[39]};
        ge    = (w >= {1'b0, d});
        y.rem = ge ? 48'(w - {1'b0, d}) : w[47:0];
        y.nq  = {x.nq[38:0], ge};
        return y;
    endfunction

    always_comb begin
        t_lane cur;
        w_den[0] = i_den;
        for (int l = 0; l < 3; l++) begin
            w_src[0][l] = '{rem: {24'b0, i_num[l][63:40]}, nq: i_num[l][39:0]};
        end
        for (int s = 1; s < DIV_STAGES; s++) begin
            w_den[s] = r_den[s-1];
            for (int l = 0; l < 3; l++) begin
                w_src[s][l] = r_ln[s-1][l];
            end
        end
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int l = 0; l < 3; l++) begin
                cur = w_src[s][l];
                for (int k = 0; k < DIV_STEPS; k++) begin
                    cur = div_step(cur, w_den[s]);
                end
                n_ln[s][l] = cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_den[s] <= w_den[s];
                for (int l = 0; l < 3; l++) begin
                    r_ln[s][l] <= n_ln[s][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_quo[l] = r_ln[DIV_STAGES-1][l].nq;
        end
    end

endmodule

@@ rtl/relativistic_boris_push.sv @@
// Relativistic Boris push, one particle per cycle while the output is not stalled, fully pipelined.
// Throughput one item per cycle while the output is not stalled.
// The pipe includes the 16-stage square root and the two 20-stage dividers.
// Output back-pressure freezes the whole pipe; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and both scale registers.
module relativistic_boris_push import bp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_reg    i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef struct packed {
        logic             sat;
        logic [2:0][31:0] a;
        logic [2:0][31:0] u1;
        logic [2:0][63:0] pb;
    } t_sb_sq;

    typedef struct packed {
        logic             sat;
        logic [2:0][31:0] a;
        logic [2:0][31:0] u1;
        logic [2:0]       neg;
    } t_sb_dt;

    typedef struct packed {
        logic             sat;
        logic [2:0][31:0] a;
        logic [2:0][31:0] u1;
        logic [2:0][31:0] up;
        logic [2:0]       neg;
    } t_sb_ds;

    logic w_en;
    logic signed [31:0] r_ekick, r_mrot;
    logic signed [31:0] w_u [3], w_e [3], w_b [3];

    // stage A
    logic r_a_v;
    logic signed [31:0] r_a_u [3];
    logic signed [63:0] r_a_pe [3], r_a_pb [3];
    // stage B
    logic r_b_v, r_b_sat, n_b_sat;
    logic signed [31:0] r_b_u [3], r_b_a [3], n_b_a [3];
    logic signed [63:0] r_b_pb [3];
    // stage C
    logic r_c_v, r_c_sat, n_c_sat;
    logic signed [31:0] r_c_a [3], r_c_u1 [3], n_c_u1 [3];
    logic signed [63:0] r_c_pb [3];
    // stage D
    logic r_d_v, r_d_sat;
    logic signed [31:0] r_d_a [3], r_d_u1 [3];
    logic signed [63:0] r_d_pb [3], r_d_sq [3];
    // stage E
    logic r_e_v, r_e_sat;
    logic signed [31:0] r_e_a [3], r_e_u1 [3];
    logic signed [63:0] r_e_pb [3];
    logic [63:0] r_e_rad;
    // square root
    t_sb_sq r_sq_sb [SQ_STAGES];
    t_sb_sq w_sq_in, w_sq_out;
    logic   r_sq_v [SQ_STAGES];
    logic [31:0] w_root;
    // stage F
    logic r_f_v, r_f_sat;
    logic signed [31:0] r_f_a [3], r_f_u1 [3];
    logic [2:0] r_f_neg, n_f_neg;
    logic [2:0][63:0] r_f_num, n_f_num;
    logic [47:0] r_f_den;
    // first divider
    t_sb_dt r_dt_sb [DIV_STAGES];
    t_sb_dt w_dt_in, w_dt_out;
    logic   r_dt_v [DIV_STAGES];
    logic [2:0][39:0] w_qt;
    // stage G
    logic r_g_v, r_g_sat, n_g_sat;
    logic signed [31:0] r_g_a [3], r_g_u1 [3], r_g_t [3], n_g_t [3];
    // stage H
    logic r_h_v, r_h_sat;
    logic signed [31:0] r_h_a [3], r_h_u1 [3], r_h_t [3];
    logic signed [63:0] r_h_x [6], r_h_tsq [3];
    // stage I
    logic r_i_v, r_i_sat, n_i_sat;
    logic signed [31:0] r_i_a [3], r_i_u1 [3], r_i_t [3], r_i_c [3], n_i_c [3];
    logic [63:0] r_i_tsum;
    // stage J
    logic r_j_v, r_j_sat, n_j_sat;
    logic signed [31:0] r_j_a [3], r_j_u1 [3], r_j_t [3], r_j_up [3], n_j_up [3];
    logic [47:0] r_j_dens;
    // stage K
    logic r_k_v, r_k_sat;
    logic signed [31:0] r_k_a [3], r_k_u1 [3], r_k_up [3];
    logic [2:0] r_k_neg, n_k_neg;
    logic [2:0][63:0] r_k_snum, n_k_snum;
    logic [47:0] r_k_dens;
    // second divider
    t_sb_ds r_ds_sb [DIV_STAGES];
    t_sb_ds w_ds_in, w_ds_out;
    logic   r_ds_v [DIV_STAGES];
    logic [2:0][39:0] w_qs;
    // stage L
    logic r_l_v, r_l_sat, n_l_sat;
    logic signed [31:0] r_l_a [3], r_l_u1 [3], r_l_up [3], r_l_s [3], n_l_s [3];
    // stage M
    logic r_m_v, r_m_sat;
    logic signed [31:0] r_m_a [3], r_m_u1 [3];
    logic signed [63:0] r_m_x [6];
    // stage N
    logic r_n_v, r_n_sat, n_n_sat;
    logic signed [31:0] r_n_a [3], r_n_u1 [3], r_n_c [3], n_n_c [3];
    // stage O
    logic r_o_v, r_o_sat, n_o_sat;
    logic signed [31:0] r_o_a [3], r_o_u2 [3], n_o_u2 [3];
    // output register
    logic r_out_v;
    t_out_item r_out, n_out;

    assign w_en        = !r_out_v || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ekick <= '0;
            r_mrot  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_EKICK: r_ekick <= i_cfg_data;
                CFG_MROT:  r_mrot  <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        w_u[0] = i_in_data.mom_z;
        w_u[1] = i_in_data.mom_r;
        w_u[2] = i_in_data.mom_phi;
        w_e[0] = i_in_data.efield_z;
        w_e[1] = i_in_data.efield_r;
        w_e[2] = i_in_data.efield_phi;
        w_b[0] = i_in_data.bfield_z;
        w_b[1] = i_in_data.bfield_r;
        w_b[2] = i_in_data.bfield_phi;
    end

    // ---------------- combinational stage logic ----------------
    always_comb begin
        logic [32:0] w;
        n_b_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w = sat32(rnd24(66'(r_a_pe[i])));
            n_b_a[i] = w[31:0];
            n_b_sat  = n_b_sat | w[32];
        end
    end

    always_comb begin
        logic [32:0] w;
        n_c_sat = r_b_sat;
        for (int i = 0; i < 3; i++) begin
            w = sat32(66'(r_b_u[i]) + 66'(r_b_a[i]));
            n_c_u1[i] = w[31:0];
            n_c_sat   = n_c_sat | w[32];
        end
    end

    always_comb begin
        w_sq_in.sat = r_e_sat;
        for (int i = 0; i < 3; i++) begin
            w_sq_in.a[i]  = r_e_a[i];
            w_sq_in.u1[i] = r_e_u1[i];
            w_sq_in.pb[i] = r_e_pb[i];
        end
    end

    assign w_sq_out = r_sq_sb[SQ_STAGES-1];

    // numerator for t carries half the divisor for round to nearest
    always_comb begin
        logic signed [63:0] pb;
        logic [63:0]        m;
        for (int i = 0; i < 3; i++) begin
            pb         = $signed(w_sq_out.pb[i]);
            n_f_neg[i] = pb[63];
            m          = pb[63] ? 64'(-pb) : 64'(pb);
            n_f_num[i] = m + {33'b0, w_root[31:1]};
        end
    end

    always_comb begin
        w_dt_in.sat = r_f_sat;
        w_dt_in.neg = r_f_neg;
        for (int i = 0; i < 3; i++) begin
            w_dt_in.a[i]  = r_f_a[i];
            w_dt_in.u1[i] = r_f_u1[i];
        end
    end

    assign w_dt_out = r_dt_sb[DIV_STAGES-1];

    always_comb begin
        logic [32:0] w;
        n_g_sat = w_dt_out.sat;
        for (int i = 0; i < 3; i++) begin
            w = sat32(w_dt_out.neg[i] ? -66'(w_qt[i]) : 66'(w_qt[i]));
            n_g_t[i] = w[31:0];
            n_g_sat  = n_g_sat | w[32];
        end
    end

    always_comb begin
        logic [32:0] w;
        n_i_sat = r_h_sat;
        for (int i = 0; i < 3; i++) begin
            w = sat32(rnd24(66'(r_h_x[2*i]) - 66'(r_h_x[2*i+1])));
            n_i_c[i] = w[31:0];
            n_i_sat  = n_i_sat | w[32];
        end
    end

    always_comb begin
        logic [32:0] w;
        n_j_sat = r_i_sat;
        for (int i = 0; i < 3; i++) begin
            w = sat32(66'(r_i_u1[i]) + 66'(r_i_c[i]));
            n_j_up[i] = w[31:0];
            n_j_sat   = n_j_sat | w[32];
        end
    end

    always_comb begin
        logic [63:0] m;
        for (int i = 0; i < 3; i++) begin
            n_k_neg[i]  = r_j_t[i][31];
            m           = 64'(r_j_t[i][31] ? -66'(r_j_t[i]) : 66'(r_j_t[i]));
            n_k_snum[i] = (m << 25) + {17'b0, r_j_dens[47:1]};
        end
    end

    always_comb begin
        w_ds_in.sat = r_k_sat;
        w_ds_in.neg = r_k_neg;
        for (int i = 0; i < 3; i++) begin
            w_ds_in.a[i]  = r_k_a[i];
            w_ds_in.u1[i] = r_k_u1[i];
            w_ds_in.up[i] = r_k_up[i];
        end
    end

    assign w_ds_out = r_ds_sb[DIV_STAGES-1];

    always_comb begin
        logic [32:0] w;
        n_l_sat = w_ds_out.sat;
        for (int i = 0; i < 3; i++) begin
            w = sat32(w_ds_out.neg[i] ? -66'(w_qs[i]) : 66'(w_qs[i]));
            n_l_s[i] = w[31:0];
            n_l_sat  = n_l_sat | w[32];
        end
    end

    always_comb begin
        logic [32:0] w;
        n_n_sat = r_m_sat;
        for (int i = 0; i < 3; i++) begin
            w = sat32(rnd24(66'(r_m_x[2*i]) - 66'(r_m_x[2*i+1])));
            n_n_c[i] = w[31:0];
            n_n_sat  = n_n_sat | w[32];
        end
    end

    always_comb begin
        logic [32:0] w;
        n_o_sat = r_n_sat;
        for (int i = 0; i < 3; i++) begin
            w = sat32(66'(r_n_u1[i]) + 66'(r_n_c[i]));
            n_o_u2[i] = w[31:0];
            n_o_sat   = n_o_sat | w[32];
        end
    end

    always_comb begin
        logic [32:0] wz, wr, wp;
        wz = sat32(66'(r_o_u2[0]) + 66'(r_o_a[0]));
        wr = sat32(66'(r_o_u2[1]) + 66'(r_o_a[1]));
        wp = sat32(66'(r_o_u2[2]) + 66'(r_o_a[2]));
        n_out.new_mom_z   = wz[31:0];
        n_out.new_mom_r   = wr[31:0];
        n_out.new_mom_phi = wp[31:0];
        n_out.saturated   = r_o_sat | wz[32] | wr[32] | wp[32];
    end

    // ---------------- arithmetic units ----------------
    bp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_e_rad),
        .o_root (w_root)
    );

    bp_div u_div_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_f_num),
        .i_den (r_f_den),
        .o_quo (w_qt)
    );

    bp_div u_div_s (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_k_snum),
        .i_den (r_k_dens),
        .o_quo (w_qs)
    );

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0; r_b_v <= 1'b0; r_c_v <= 1'b0; r_d_v <= 1'b0;
            r_e_v <= 1'b0; r_f_v <= 1'b0; r_g_v <= 1'b0; r_h_v <= 1'b0;
            r_i_v <= 1'b0; r_j_v <= 1'b0; r_k_v <= 1'b0; r_l_v <= 1'b0;
            r_m_v <= 1'b0; r_n_v <= 1'b0; r_o_v <= 1'b0; r_out_v <= 1'b0;
            for (int s = 0; s < SQ_STAGES; s++) begin
                r_sq_v[s] <= 1'b0;
            end
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_dt_v[s] <= 1'b0;
                r_ds_v[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_sq_v[0] <= r_e_v;
            for (int s = 1; s < SQ_STAGES; s++) begin
                r_sq_v[s] <= r_sq_v[s-1];
            end
            r_f_v <= r_sq_v[SQ_STAGES-1];
            r_dt_v[0] <= r_f_v;
            r_ds_v[0] <= r_k_v;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_dt_v[s] <= r_dt_v[s-1];
                r_ds_v[s] <= r_ds_v[s-1];
            end
            r_g_v <= r_dt_v[DIV_STAGES-1];
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
            r_j_v <= r_i_v;
            r_k_v <= r_j_v;
            r_l_v <= r_ds_v[DIV_STAGES-1];
            r_m_v <= r_l_v;
            r_n_v <= r_m_v;
            r_o_v <= r_n_v;
            r_out_v <= r_o_v;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_u[i]  <= w_u[i];
                r_a_pe[i] <= 64'(w_e[i]) * 64'(r_ekick);
                r_a_pb[i] <= 64'(w_b[i]) * 64'(r_mrot);

                r_b_u[i]  <= r_a_u[i];
                r_b_a[i]  <= n_b_a[i];
                r_b_pb[i] <= r_a_pb[i];

                r_c_a[i]  <= r_b_a[i];
                r_c_u1[i] <= n_c_u1[i];
                r_c_pb[i] <= r_b_pb[i];

                r_d_a[i]  <= r_c_a[i];
                r_d_u1[i] <= r_c_u1[i];
                r_d_pb[i] <= r_c_pb[i];
                r_d_sq[i] <= 64'(r_c_u1[i]) * 64'(r_c_u1[i]);

                r_e_a[i]  <= r_d_a[i];
                r_e_u1[i] <= r_d_u1[i];
                r_e_pb[i] <= r_d_pb[i];

                r_f_a[i]  <= $signed(w_sq_out.a[i]);
                r_f_u1[i] <= $signed(w_sq_out.u1[i]);

                r_g_a[i]  <= $signed(w_dt_out.a[i]);
                r_g_u1[i] <= $signed(w_dt_out.u1[i]);
                r_g_t[i]  <= n_g_t[i];

                r_h_a[i]   <= r_g_a[i];
                r_h_u1[i]  <= r_g_u1[i];
                r_h_t[i]   <= r_g_t[i];
                r_h_tsq[i] <= 64'(r_g_t[i]) * 64'(r_g_t[i]);

                r_i_a[i]  <= r_h_a[i];
                r_i_u1[i] <= r_h_u1[i];
                r_i_t[i]  <= r_h_t[i];
                r_i_c[i]  <= n_i_c[i];

                r_j_a[i]  <= r_i_a[i];
                r_j_u1[i] <= r_i_u1[i];
                r_j_t[i]  <= r_i_t[i];
                r_j_up[i] <= n_j_up[i];

                r_k_a[i]  <= r_j_a[i];
                r_k_u1[i] <= r_j_u1[i];
                r_k_up[i] <= r_j_up[i];

                r_l_a[i]  <= $signed(w_ds_out.a[i]);
                r_l_u1[i] <= $signed(w_ds_out.u1[i]);
                r_l_up[i] <= $signed(w_ds_out.up[i]);
                r_l_s[i]  <= n_l_s[i];

                r_m_a[i]  <= r_l_a[i];
                r_m_u1[i] <= r_l_u1[i];

                r_n_a[i]  <= r_m_a[i];
                r_n_u1[i] <= r_m_u1[i];
                r_n_c[i]  <= n_n_c[i];

                r_o_a[i]  <= r_n_a[i];
                r_o_u2[i] <= n_o_u2[i];
            end
            r_b_sat <= n_b_sat;
            r_c_sat <= n_c_sat;
            r_d_sat <= r_c_sat;
            r_e_sat <= r_d_sat;
            r_e_rad <= 64'h0001_0000_0000_0000 + $unsigned(r_d_sq[0])
                       + $unsigned(r_d_sq[1]) + $unsigned(r_d_sq[2]);

            r_sq_sb[0] <= w_sq_in;
            for (int s = 1; s < SQ_STAGES; s++) begin
                r_sq_sb[s] <= r_sq_sb[s-1];
            end

            r_f_sat <= w_sq_out.sat;
            r_f_neg <= n_f_neg;
            r_f_num <= n_f_num;
            r_f_den <= {16'b0, w_root};

            r_dt_sb[0] <= w_dt_in;
            r_ds_sb[0] <= w_ds_in;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_dt_sb[s] <= r_dt_sb[s-1];
                r_ds_sb[s] <= r_ds_sb[s-1];
            end

            r_g_sat <= n_g_sat;

            // cross product u1 x t
            r_h_x[0] <= 64'(r_g_u1[1]) * 64'(r_g_t[2]);
            r_h_x[1] <= 64'(r_g_u1[2]) * 64'(r_g_t[1]);
            r_h_x[2] <= 64'(r_g_u1[2]) * 64'(r_g_t[0]);
            r_h_x[3] <= 64'(r_g_u1[0]) * 64'(r_g_t[2]);
            r_h_x[4] <= 64'(r_g_u1[0]) * 64'(r_g_t[1]);
            r_h_x[5] <= 64'(r_g_u1[1]) * 64'(r_g_t[0]);
            r_h_sat  <= r_g_sat;

            r_i_sat  <= n_i_sat;
            r_i_tsum <= $unsigned(r_h_tsq[0]) + $unsigned(r_h_tsq[1])
                        + $unsigned(r_h_tsq[2]) + 64'd8388608;

            r_j_sat  <= n_j_sat;
            r_j_dens <= 48'(64'd16777216 + (r_i_tsum >> 24));

            r_k_sat  <= r_j_sat;
            r_k_neg  <= n_k_neg;
            r_k_snum <= n_k_snum;
            r_k_dens <= r_j_dens;

            r_l_sat <= n_l_sat;

            // cross product u' x s
            r_m_x[0] <= 64'(r_l_up[1]) * 64'(r_l_s[2]);
            r_m_x[1] <= 64'(r_l_up[2]) * 64'(r_l_s[1]);
            r_m_x[2] <= 64'(r_l_up[2]) * 64'(r_l_s[0]);
            r_m_x[3] <= 64'(r_l_up[0]) * 64'(r_l_s[2]);
            r_m_x[4] <= 64'(r_l_up[0]) * 64'(r_l_s[1]);
            r_m_x[5] <= 64'(r_l_up[1]) * 64'(r_l_s[0]);
            r_m_sat  <= r_l_sat;

            r_n_sat <= n_n_sat;
            r_o_sat <= n_o_sat;
            r_out   <= n_out;
        end
    end

    // ---------------- assertions ----------------
    // gamma is at least 1.0, so the first divisor never drops below 2^24
    a_gamma_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_v |-> r_f_den >= 48'h100_0000)
        else $error("gamma below one entering divider");

    a_dens_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k_v |-> r_k_dens >= 48'h100_0000)
        else $error("s denominator below one entering divider");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_o_v) && $stable(r_k_v) && $stable(r_f_v))
        else $error("pipeline moved during stall");

endmodule

@@ test/relativistic_boris_push_tb.sv @@
// Self-checking testbench for relativistic_boris_push.
// Streams particles through the valid/ready channels and checks results against an
// in-bench Boris push predictor. Depends on bp_pkg and relativistic_boris_push.
`timescale 1ns / 100ps

module relativistic_boris_push_tb;
    import bp_pkg::*;

    typedef logic signed [71:0] t_wide;

    localparam int PIPE_LAT = 72;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_LEN = 300;
    localparam int HOLD_AT = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_reg    i_cfg_index = CFG_EKICK;
    logic [31:0] i_cfg_data = '0;

    t_in_item  particle_q[$];
    t_out_item push_exp_q[$];

    t_q kick_scale = '0;
    t_q rot_scale = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int n_results = 0;
    int hold_cnt = 0;
    int idle_cycles = 0;
    bit hold_done = 1'b0;

    relativistic_boris_push DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- Boris push predictor ----------------
    function automatic t_q clip_q(input t_wide x, inout logic flag);
        if (x > 72'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (x < -72'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return t_q'(x[31:0]);
    endfunction

    function automatic t_wide rnd_q24(input t_wide x);
        return (x + 72'sd8388608) >>> 24;
    endfunction

    // round to nearest, ties away from zero
    function automatic t_wide div_nearest(input t_wide num, input logic [63:0] den);
        logic [71:0] m;
        logic [71:0] q;
        m = (num < 0) ? 72'(-num) : 72'(num);
        q = (m + 72'(den / 2)) / 72'(den);
        return (num < 0) ? -t_wide'(q) : t_wide'(q);
    endfunction

    // sum of squares wraps at 64 bits
    function automatic logic [63:0] sq_sum(input t_q v[3]);
        logic [63:0] s;
        logic [63:0] m;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            m = (v[i] < 0) ? 64'(-t_wide'(v[i])) : 64'(v[i]);
            s = s + m * m;
        end
        return s;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic void cross_accum(input t_q base[3], input t_q a[3], input t_q b[3],
                                        output t_q res[3], inout logic flag);
        t_wide c[3];
        t_q    cc;
        c[0] = rnd_q24(t_wide'(a[1]) * t_wide'(b[2]) - t_wide'(a[2]) * t_wide'(b[1]));
        c[1] = rnd_q24(t_wide'(a[2]) * t_wide'(b[0]) - t_wide'(a[0]) * t_wide'(b[2]));
        c[2] = rnd_q24(t_wide'(a[0]) * t_wide'(b[1]) - t_wide'(a[1]) * t_wide'(b[0]));
        for (int i = 0; i < 3; i++) begin
            cc = clip_q(c[i], flag);
            res[i] = clip_q(t_wide'(base[i]) + t_wide'(cc), flag);
        end
    endfunction

    function automatic t_out_item boris_push(input t_in_item p);
        t_q u[3], e[3], b[3], a[3], u1[3], t[3], up[3], s[3], u2[3];
        logic flag;
        logic [63:0] g, den;
        t_out_item r;
        flag = 1'b0;
        u = '{p.mom_z, p.mom_r, p.mom_phi};
        e = '{p.efield_z, p.efield_r, p.efield_phi};
        b = '{p.bfield_z, p.bfield_r, p.bfield_phi};
        for (int i = 0; i < 3; i++) begin
            a[i] = clip_q(rnd_q24(t_wide'(e[i]) * t_wide'(kick_scale)), flag);
            u1[i] = clip_q(t_wide'(u[i]) + t_wide'(a[i]), flag);
        end
        g = int_sqrt((64'd1 << 48) + sq_sum(u1));
        for (int i = 0; i < 3; i++)
            t[i] = clip_q(div_nearest(t_wide'(b[i]) * t_wide'(rot_scale), g), flag);
        cross_accum(u1, u1, t, up, flag);
        den = (64'd1 << 24) + ((sq_sum(t) + (64'd1 << 23)) >> 24);
        for (int i = 0; i < 3; i++)
            s[i] = clip_q(div_nearest(t_wide'(t[i]) <<< 25, den), flag);
        cross_accum(u1, up, s, u2, flag);
        r.new_mom_z = clip_q(t_wide'(u2[0]) + t_wide'(a[0]), flag);
        r.new_mom_r = clip_q(t_wide'(u2[1]) + t_wide'(a[1]), flag);
        r.new_mom_phi = clip_q(t_wide'(u2[2]) + t_wide'(a[2]), flag);
        r.saturated = flag;
        return r;
    endfunction

    function automatic void add_particle(input t_in_item p);
        particle_q.insert(particle_q.size(), p);
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                push_exp_q.insert(push_exp_q.size(), boris_push(i_in_data));
            if (!i_in_valid || o_in_ready) begin
                if (particle_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data <= particle_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results <= n_results + 1;
                if (push_exp_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h", o_out_data);
                end else begin
                    want = push_exp_q.pop_front();
                    if (want !== o_out_data) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch exp %h %h %h %b got %h %h %h %b",
                                     want.new_mom_z, want.new_mom_r, want.new_mom_phi,
                                     want.saturated, o_out_data.new_mom_z,
                                     o_out_data.new_mom_r, o_out_data.new_mom_phi,
                                     o_out_data.saturated);
                    end
                end
            end
            if (hold_cnt > 0)
                i_out_ready <= 1'b0;
            else
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one long hold-off to back up the pipe and stall the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (!hold_done && n_results == HOLD_AT) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_LEN;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // config shadow
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_EKICK: kick_scale <= t_q'(i_cfg_data);
                CFG_MROT:  rot_scale <= t_q'(i_cfg_data);
            endcase
        end
    end

    // watchdog: cycles without any transfer, not counted during the hold-off or reset
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || hold_cnt > 0
                || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("relativistic_boris_push_tb: FAIL");
            $finish;
        end
    end

    task automatic cfg_write(input t_cfg_reg idx, input t_q val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_q rand_q(input int span_bits, input bit full);
        if (full)
            return t_q'($urandom);
        return t_q'($urandom_range((1 << span_bits) - 1)) - t_q'(1 << (span_bits - 1));
    endfunction

    function automatic t_in_item rand_particle();
        t_in_item p;
        bit full;
        full = ($urandom_range(9) >= 7);
        p.mom_z = rand_q(27, full);
        p.mom_r = rand_q(27, full);
        p.mom_phi = rand_q(27, full);
        p.efield_z = rand_q(29, full);
        p.efield_r = rand_q(29, full);
        p.efield_phi = rand_q(29, full);
        p.bfield_z = rand_q(29, full);
        p.bfield_r = rand_q(29, full);
        p.bfield_phi = rand_q(29, full);
        return p;
    endfunction

    task automatic run_phase(input t_q ek, input t_q mr, input int idle, input int stall,
                             input int n_items, input bit directed);
        t_q qmax, qmin, one;
        qmax = 32'sh7fffffff;
        qmin = 32'sh80000000;
        one = 32'sh01000000;
        cfg_write(CFG_EKICK, ek);
        cfg_write(CFG_MROT, mr);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        if (directed) begin
            add_particle('0);
            add_particle('{default: qmax});
            add_particle('{default: qmin});
            add_particle('{qmax, qmin, qmax, 0, 0, 0, 0, 0, 0});
            add_particle('{0, 0, 0, qmax, qmin, qmax, 0, 0, 0});
            add_particle('{0, 0, 0, 0, 0, 0, qmax, qmin, qmax});
            add_particle('{one, 0, 0, 0, 0, 0, one, 0, 0});
            add_particle('{one, -one, one, one, one, -one, -one, one, one});
            add_particle('{qmin, qmin, qmin, qmin, qmin, qmin, qmax, qmax, qmax});
            add_particle('{0, one, 0, 0, 0, one, qmin, 0, 0});
            add_particle('{-1, 1, -1, 1, -1, 1, -1, 1, -1});
            add_particle('{one <<< 5, 0, -(one <<< 5), 0, 0, 0, 0, one <<< 4, 0});
        end
        repeat (n_items) add_particle(rand_particle());
        // sample between edges so every update of the edge has settled
        @(negedge i_clk);
        while (particle_q.size() != 0 || i_in_valid || push_exp_q.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(32'sd167772, 32'sd8388608, 0, 0, 250, 1'b1);
        run_phase(32'sd0, 32'sd0, 0, 0, 250, 1'b1);
        run_phase(32'sh7fffffff, 32'sh80000000, 55, 0, 250, 1'b1);
        run_phase(32'sh80000000, 32'sh7fffffff, 0, 55, 250, 1'b0);
        run_phase(-32'sd335544, 32'sd33554432, 25, 25, 200, 1'b0);
        run_phase(t_q'($urandom), t_q'($urandom), 0, 0, 200, 1'b0);
        if (mismatches == 0)
            $display("relativistic_boris_push_tb: PASS");
        else
            $display("relativistic_boris_push_tb: FAIL");
        $finish;
    end

endmodule
